### src/qlc_pkg.sv
// Shared types and constants for the quadtree leaf counter.
// No dependencies; imported by every module of the block.
package qlc_pkg;

    // Fixed field widths
    localparam int CFG_W         = 4;
    localparam int COUNT_W       = 21;
    localparam int CNT3_W        = 3;
    localparam int ENTRY_W       = 2 * CNT3_W;
    localparam int CHILDREN      = 4;

    // Defaults
    localparam int LOG2_MAX_SIDE_DEF = 10;
    localparam logic [CFG_W-1:0] LOG2_SIDE_RST = 4'd3;

    // Sequencer states
    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    // Memory port strobes from the sequencer to the store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

endpackage

### src/qlc_store.sv
// Merge store: per level and block column, counts of uniform children.
// Single write port, single read port with registered data. Uses qlc_pkg.
module qlc_store #(
    parameter int ADDR_W = qlc_pkg::LOG2_MAX_SIDE_DEF
) (
    input  logic                          i_clk,
    input  qlc_pkg::t_mem_ctl             i_ctl,
    input  logic [ADDR_W-1:0]             i_waddr,
    input  logic [qlc_pkg::ENTRY_W-1:0]   i_wdata,
    input  logic [ADDR_W-1:0]             i_raddr,
    output logic [qlc_pkg::ENTRY_W-1:0]   o_rdata
);
    import qlc_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered; data holds between reads
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/qlc_walk.sv
// Level sequencer: walks one pixel up the tree levels, read-modify-write
// on the merge store, keeps the leaf tallies and the result register. Uses qlc_pkg.
module qlc_walk #(
    parameter int LOG2_MAX_SIDE = qlc_pkg::LOG2_MAX_SIDE_DEF,
    parameter int LW            = $clog2(LOG2_MAX_SIDE + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [LW-1:0]                 i_k,
    input  logic                          i_cfg_we,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_pixel,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [qlc_pkg::COUNT_W-1:0]   o_zero_leaves,
    output logic [qlc_pkg::COUNT_W-1:0]   o_one_leaves,
    output qlc_pkg::t_mem_ctl             o_mem_ctl,
    output logic [LOG2_MAX_SIDE-1:0]      o_waddr,
    output logic [qlc_pkg::ENTRY_W-1:0]   o_wdata,
    output logic [LOG2_MAX_SIDE-1:0]      o_raddr,
    input  logic [qlc_pkg::ENTRY_W-1:0]   i_rdata
);
    import qlc_pkg::*;

    localparam int L    = LOG2_MAX_SIDE;
    localparam int SW   = L + 1;
    localparam int PW   = 2 * L;
    localparam int SHW  = $clog2(PW);

    t_state                r_state, n_state;
    logic [PW-1:0]         r_pos, n_pos;
    logic [LW-1:0]         r_lvl, n_lvl;
    logic                  r_uni, n_uni;
    logic                  r_val, n_val;
    logic [COUNT_W-1:0]    r_zero, n_zero;
    logic [COUNT_W-1:0]    r_one, n_one;
    logic                  r_out_valid, n_out_valid;
    logic [COUNT_W-1:0]    r_out_zero, n_out_zero;
    logic [COUNT_W-1:0]    r_out_one, n_out_one;

    logic [SW-1:0]         side;
    logic [PW-1:0]         last_pos;
    logic                  pos_last;
    logic [L-1:0]          col;
    logic [LW-1:0]         rd_lvl;
    logic [LW-1:0]         sh;
    logic                  rb, cb;
    logic [ENTRY_W-1:0]    ent;
    logic [CNT3_W-1:0]     zeros, ones;
    logic [CNT3_W-1:0]     add_z, add_o;
    logic                  fin;
    logic                  out_busy;
    logic [COUNT_W-1:0]    sum_zero, sum_one;

    // Store address of a block at a given level: base of the level plus column
    function automatic logic [L-1:0] level_addr(
        input logic [LW-1:0] lvl,
        input logic [SW-1:0] sd,
        input logic [L-1:0]  cl
    );
        logic [SW-1:0] base;
        logic [SW-1:0] colsh;
        base  = sd - (sd >> (lvl - LW'(1)));
        colsh = SW'(cl) >> lvl;
        return L'(base + colsh);
    endfunction

    // Image geometry
    always_comb begin
        side     = SW'(1) << i_k;
        last_pos = (PW'(1) << (PW'(i_k) << 1)) - PW'(1);
        pos_last = (r_pos == last_pos);
        col      = r_pos[L-1:0] & L'(side - SW'(1));
        out_busy = r_out_valid && !i_ready;
    end

    // Current level: child position bits and updated entry
    always_comb begin
        sh    = r_lvl - LW'(1);
        cb    = col[sh];
        rb    = r_pos[SHW'(i_k) + SHW'(sh)];
        ent   = (!rb && !cb) ? '0 : i_rdata;
        zeros = ent[CNT3_W-1:0];
        ones  = ent[ENTRY_W-1:CNT3_W];
        if (r_uni) begin
            if (r_val) begin
                if (ones != '1) ones = ones + CNT3_W'(1);
            end else begin
                if (zeros != '1) zeros = zeros + CNT3_W'(1);
            end
        end
    end

    // Sequencer: next state, store strobes, tallies
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_lvl       = r_lvl;
        n_uni       = r_uni;
        n_val       = r_val;
        n_zero      = r_zero;
        n_one       = r_one;
        n_out_valid = out_busy ? 1'b1 : 1'b0;
        n_out_zero  = r_out_zero;
        n_out_one   = r_out_one;
        o_mem_ctl   = '0;
        fin         = 1'b0;
        add_z       = '0;
        add_o       = '0;
        rd_lvl      = (r_state == S_IDLE) ? LW'(1) : r_lvl + LW'(1);
        o_raddr     = level_addr(rd_lvl, side, col);
        o_waddr     = level_addr(r_lvl, side, col);
        o_wdata     = {ones, zeros};
        o_ready     = (r_state == S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_mem_ctl.rd_en = 1'b1;
                    n_val   = i_pixel;
                    n_uni   = 1'b1;
                    n_lvl   = LW'(1);
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                // Work out what this level does
                if (i_k == '0) begin
                    fin   = 1'b1;
                    add_z = CNT3_W'(!r_val);
                    add_o = CNT3_W'(r_val);
                end else if (!(rb && cb)) begin
                    fin = 1'b1;
                end else if (zeros == CNT3_W'(CHILDREN) || ones == CNT3_W'(CHILDREN)) begin
                    n_uni = 1'b1;
                    n_val = (ones == CNT3_W'(CHILDREN));
                    if (r_lvl == i_k) begin
                        fin   = 1'b1;
                        add_z = CNT3_W'(ones != CNT3_W'(CHILDREN));
                        add_o = CNT3_W'(ones == CNT3_W'(CHILDREN));
                    end
                end else begin
                    n_uni = 1'b0;
                    add_z = zeros;
                    add_o = ones;
                    fin   = (r_lvl == i_k);
                end

                // Hold everything while a finished image waits on the output
                if (fin && pos_last && out_busy) begin
                    n_uni = r_uni;
                    n_val = r_val;
                end else begin
                    o_mem_ctl.wr_en = (i_k != '0);
                    n_zero = r_zero + COUNT_W'(add_z);
                    n_one  = r_one + COUNT_W'(add_o);
                    if (fin) begin
                        n_state = S_IDLE;
                        if (pos_last) begin
                            n_out_valid = 1'b1;
                            n_out_zero  = n_zero;
                            n_out_one   = n_one;
                            n_zero      = '0;
                            n_one       = '0;
                            n_pos       = '0;
                        end else begin
                            n_pos = r_pos + PW'(1);
                        end
                    end else begin
                        o_mem_ctl.rd_en = 1'b1;
                        n_lvl = r_lvl + LW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // New side length starts a new image
        if (i_cfg_we) begin
            n_pos  = '0;
            n_zero = '0;
            n_one  = '0;
        end
    end

    assign sum_zero = n_zero;
    assign sum_one  = n_one;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_zero      <= '0;
            r_one       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_zero      <= sum_zero;
            r_one       <= sum_one;
            r_out_valid <= n_out_valid;
        end
    end

    // Per-pixel working registers and result payload
    always_ff @(posedge i_clk) begin
        r_lvl      <= n_lvl;
        r_uni      <= n_uni;
        r_val      <= n_val;
        r_out_zero <= n_out_zero;
        r_out_one  <= n_out_one;
    end

    assign o_valid       = r_out_valid;
    assign o_zero_leaves = r_out_zero;
    assign o_one_leaves  = r_out_one;

endmodule

### src/quadtree_leaf_counter.sv
// Quadtree leaf counter: pixel in, zero/one leaf counts out per image.
// A pixel is taken in the idle state, then walks at least one tree level, climbing on
// while it is the last pixel of a block; no new pixel is taken until its walk ends.
// Counts are registered as the last pixel's final level ends; it stalls while older counts wait.
// Synchronous reset: side register to 3, position and tallies to zero.
// The merge store needs no clearing pass; entries are written before read.
module quadtree_leaf_counter #(
    parameter int LOG2_MAX_SIDE = qlc_pkg::LOG2_MAX_SIDE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [qlc_pkg::CFG_W-1:0]     i_log2_side,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_pixel,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [qlc_pkg::COUNT_W-1:0]   o_zero_leaves,
    output logic [qlc_pkg::COUNT_W-1:0]   o_one_leaves
);
    import qlc_pkg::*;

    localparam int LW = $clog2(LOG2_MAX_SIDE + 1);

    logic [CFG_W-1:0]          r_log2_side;
    logic [LW-1:0]             eff_k;
    t_mem_ctl                  mem_ctl;
    logic [LOG2_MAX_SIDE-1:0]  waddr, raddr;
    logic [ENTRY_W-1:0]        wdata, rdata;

    // Side length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2_side <= LOG2_SIDE_RST;
        end else if (i_cfg_we) begin
            r_log2_side <= i_log2_side;
        end
    end

    // Oversized sides clamp to the largest supported
    assign eff_k = (r_log2_side > CFG_W'(LOG2_MAX_SIDE)) ? LW'(LOG2_MAX_SIDE)
                                                         : LW'(r_log2_side);

    qlc_walk #(
        .LOG2_MAX_SIDE (LOG2_MAX_SIDE),
        .LW            (LW)
    ) u_walk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_k           (eff_k),
        .i_cfg_we      (i_cfg_we),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel       (i_pixel),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_zero_leaves (o_zero_leaves),
        .o_one_leaves  (o_one_leaves),
        .o_mem_ctl     (mem_ctl),
        .o_waddr       (waddr),
        .o_wdata       (wdata),
        .o_raddr       (raddr),
        .i_rdata       (rdata)
    );

    qlc_store #(
        .ADDR_W (LOG2_MAX_SIDE)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule
